/* src/assert_macros.svh */
// Assertion macros for the controller of the sinc-product attention score RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a condition at every clock edge out of reset.
`define SPAS_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("spas assertion failed");
// Check that a consequence holds in the cycle after its cause.
`define SPAS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("spas assertion failed");
`else
`define SPAS_ASSERT(lbl, cond)
`define SPAS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* src/spas_pkg.sv */
// Package: types, constants and the sine table for the attention score block.
package spas_pkg;

  localparam int SINE_DEPTH = 1024;
  localparam int SINE_AW    = $clog2(SINE_DEPTH);

  localparam logic [63:0] ONE_Q30     = 64'd1073741824;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [29:0] TURNS_K     = 30'd683565276;
  localparam logic [31:0] ONE_Q23     = 32'd8388608;
  localparam logic [15:0] R_SCALE_RST = 16'd4096;

  localparam logic [63:0] HORNER_DEN [6] = '{64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};

  // Divider: one quotient bit per step over the 36 bit dividend.
  localparam int DIV_STEPS = 36;
  localparam int DIV_CW    = $clog2(DIV_STEPS);

  typedef logic signed [31:0] sine_rom_t [SINE_DEPTH];

  typedef enum logic [3:0] {
    S_IDLE,
    S_MAG,
    S_PHASE,
    S_ROM,
    S_INTERP,
    S_SINE,
    S_DIV,
    S_MULLO,
    S_MULHI,
    S_ROUND,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic load_in;
    logic mag;
    logic phase;
    logic rom;
    logic interp;
    logic sine;
    logic div_step;
    logic mul_lo;
    logic mul_hi;
    logic round;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic ax_zero;
    logic last;
    logic out_free;
  } sts_t;

  // Sine of a table phase in Q2.30: quadrant fold and odd Taylor series.
  function automatic logic signed [31:0] sine_entry(int unsigned idx);
    logic [31:0] ph;
    logic [1:0]  quad;
    logic [63:0] w;
    logic [63:0] theta;
    logic [63:0] t2;
    logic [63:0] term;
    logic [63:0] s;
    int          j;
    ph   = 32'(idx) << (32 - SINE_AW);
    quad = ph[31:30];
    w    = {34'd0, ph[29:0]};
    if (quad[0]) w = ONE_Q30 - w;
    theta = (w * HALF_PI_Q30) >> 30;
    t2    = (theta * theta) >> 30;
    term  = ONE_Q30;
    for (j = 0; j < 6; j++) begin
      term = ONE_Q30 - (((t2 * term) >> 30) / HORNER_DEN[j]);
    end
    s = (theta * term) >> 30;
    if (s > ONE_Q30) s = ONE_Q30;
    return quad[1] ? -$signed(s[31:0]) : $signed(s[31:0]);
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    for (int i = 0; i < SINE_DEPTH; i++) begin
      rom[i] = sine_entry(i);
    end
    return rom;
  endfunction

endpackage

/* src/spas_ctrl.sv */
// Controller: sequences one word through the datapath steps.
`include "assert_macros.svh"
module spas_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  spas_pkg::sts_t    sts,
  output spas_pkg::cmd_t    cmd
);

  spas_pkg::state_t              state_r, state_nxt;
  logic [spas_pkg::DIV_CW-1:0]   div_cnt_r;
  logic                          div_last;

  assign div_last = (div_cnt_r == spas_pkg::DIV_CW'(spas_pkg::DIV_STEPS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= spas_pkg::S_IDLE;
      div_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == spas_pkg::S_DIV) div_cnt_r <= div_cnt_r + 1'b1;
      else div_cnt_r <= '0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      spas_pkg::S_IDLE:   if (in_valid) state_nxt = spas_pkg::S_MAG;
      spas_pkg::S_MAG:    state_nxt = sts.ax_zero ? spas_pkg::S_MULLO : spas_pkg::S_PHASE;
      spas_pkg::S_PHASE:  state_nxt = spas_pkg::S_ROM;
      spas_pkg::S_ROM:    state_nxt = spas_pkg::S_INTERP;
      spas_pkg::S_INTERP: state_nxt = spas_pkg::S_SINE;
      spas_pkg::S_SINE:   state_nxt = spas_pkg::S_DIV;
      spas_pkg::S_DIV:    if (div_last) state_nxt = spas_pkg::S_MULLO;
      spas_pkg::S_MULLO:  state_nxt = spas_pkg::S_MULHI;
      spas_pkg::S_MULHI:  state_nxt = spas_pkg::S_ROUND;
      spas_pkg::S_ROUND:  state_nxt = sts.last ? spas_pkg::S_EMIT : spas_pkg::S_IDLE;
      spas_pkg::S_EMIT:   if (sts.out_free) state_nxt = spas_pkg::S_IDLE;
      default:            state_nxt = spas_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      spas_pkg::S_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      spas_pkg::S_MAG:    cmd.mag      = 1'b1;
      spas_pkg::S_PHASE:  cmd.phase    = 1'b1;
      spas_pkg::S_ROM:    cmd.rom      = 1'b1;
      spas_pkg::S_INTERP: cmd.interp   = 1'b1;
      spas_pkg::S_SINE:   cmd.sine     = 1'b1;
      spas_pkg::S_DIV:    cmd.div_step = 1'b1;
      spas_pkg::S_MULLO:  cmd.mul_lo   = 1'b1;
      spas_pkg::S_MULHI:  cmd.mul_hi   = 1'b1;
      spas_pkg::S_ROUND:  cmd.round    = 1'b1;
      spas_pkg::S_EMIT:   cmd.emit     = sts.out_free;
      default: ;
    endcase
  end

  `SPAS_ASSERT_NEXT(a_accept_leaves_idle, in_valid && in_ready, state_r == spas_pkg::S_MAG)
  `SPAS_ASSERT_NEXT(a_div_ends, (state_r == spas_pkg::S_DIV) && div_last, state_r == spas_pkg::S_MULLO)
  `SPAS_ASSERT(a_div_bound, (state_r != spas_pkg::S_DIV) || (div_cnt_r < spas_pkg::DIV_CW'(spas_pkg::DIV_STEPS)))
  `SPAS_ASSERT_NEXT(a_emit_done, cmd.emit, state_r == spas_pkg::S_IDLE)

endmodule

/* src/spas_dp.sv */
// Datapath: sine lookup, divider, running product and output register.
module spas_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  input  logic [15:0]         cfg_r_scale,
  input  logic signed [15:0]  in_query_elem,
  input  logic signed [15:0]  in_key_elem,
  input  logic                in_last_elem,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  out_score,
  output logic                out_saturated,
  input  spas_pkg::cmd_t      cmd,
  output spas_pkg::sts_t      sts
);

  localparam spas_pkg::sine_rom_t SINE_ROM = spas_pkg::build_sine_rom();
  localparam int AW = spas_pkg::SINE_AW;

  logic [15:0]         r_scale_r;
  logic [15:0]         ad_r;
  logic                last_r;
  logic [31:0]         ax_r;
  logic [31:0]         phase_r;
  logic signed [31:0]  a_r, b_r;
  logic [15:0]         f_r;
  logic signed [49:0]  ip_r;
  logic [15:0]         rem_r;
  logic [35:0]         quo_r;
  logic                fac_neg_r;
  logic [31:0]         pmag_r;
  logic                prod_neg_r;
  logic [67:0]         acc_r;
  logic signed [31:0]  prod_r;
  logic                ovf_r;
  logic                out_valid_r;
  logic signed [31:0]  out_score_r;
  logic                out_sat_r;

  // input magnitude
  logic signed [16:0]  d;
  logic signed [16:0]  d_neg;
  logic [15:0]         ad_nxt;
  assign d      = {in_query_elem[15], in_query_elem} - {in_key_elem[15], in_key_elem};
  assign d_neg  = -d;
  assign ad_nxt = d[16] ? d_neg[15:0] : d[15:0];

  logic [61:0] phase_prod;
  assign phase_prod = {30'd0, ax_r} * {32'd0, spas_pkg::TURNS_K};

  logic [AW-1:0] idx, idx_nx;
  assign idx    = phase_r[31 -: AW];
  assign idx_nx = idx + 1'b1;

  // interpolation: a*65536 + (b-a)*f, truncated toward zero
  logic signed [32:0]  diff;
  logic signed [49:0]  isum;
  logic signed [31:0]  sine;
  logic [30:0]         smag;
  assign diff = {b_r[31], b_r} - {a_r[31], a_r};
  assign isum = {{2{a_r[31]}}, a_r, 16'd0} + ip_r;
  assign sine = isum[47:16] + 32'((isum[49] && (isum[15:0] != 16'd0)) ? 1 : 0);
  assign smag = sine[31] ? 31'(-sine) : sine[30:0];

  // divider step
  logic [16:0] shifted;
  logic        ge;
  logic [16:0] sub;
  assign shifted = {rem_r, quo_r[35]};
  assign ge      = shifted >= {1'b0, ad_r};
  assign sub     = shifted - {1'b0, ad_r};

  logic [31:0] pmag_nxt;
  assign pmag_nxt = prod_r[31] ? 32'(-prod_r) : prod_r;

  // rounding and saturation
  logic [67:0] rnd;
  logic [44:0] qv;
  logic        neg;
  logic        sat;
  logic [31:0] res;
  assign rnd = acc_r + 68'(1 << 22);
  assign qv  = rnd[67:23];
  assign neg = prod_neg_r ^ fac_neg_r;
  always_comb begin
    if (!neg) begin
      sat = qv > 45'h0_7FFF_FFFF;
      res = sat ? 32'h7FFF_FFFF : qv[31:0];
    end else begin
      sat = qv > 45'h0_8000_0000;
      res = sat ? 32'h8000_0000 : -qv[31:0];
    end
  end

  logic out_free;
  assign out_free = !out_valid_r || out_ready;

  assign sts.ax_zero  = (ad_r == 16'd0) || (r_scale_r == 16'd0);
  assign sts.last     = last_r;
  assign sts.out_free = out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_scale_r   <= spas_pkg::R_SCALE_RST;
      prod_r      <= spas_pkg::ONE_Q23;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) r_scale_r <= cfg_r_scale;
      if (cmd.round) begin
        prod_r <= res;
        if (sat) ovf_r <= 1'b1;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
        prod_r      <= spas_pkg::ONE_Q23;
        ovf_r       <= 1'b0;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      ad_r   <= ad_nxt;
      last_r <= in_last_elem;
    end
    if (cmd.mag) begin
      ax_r <= {16'd0, ad_r} * {16'd0, r_scale_r};
      if (sts.ax_zero) begin
        // zero argument: factor is r_scale in Q13.23
        quo_r     <= {9'd0, r_scale_r, 11'd0};
        fac_neg_r <= 1'b0;
      end
    end
    if (cmd.phase) phase_r <= phase_prod[55:24];
    if (cmd.rom) begin
      a_r <= SINE_ROM[idx];
      b_r <= SINE_ROM[idx_nx];
      f_r <= phase_r[31-AW -: 16];
    end
    if (cmd.interp) ip_r <= 50'(diff * $signed({1'b0, f_r}));
    if (cmd.sine) begin
      quo_r     <= {smag, 5'd0};
      rem_r     <= '0;
      fac_neg_r <= sine[31];
    end
    if (cmd.div_step) begin
      quo_r <= {quo_r[34:0], ge};
      rem_r <= ge ? sub[15:0] : shifted[15:0];
    end
    if (cmd.mul_lo) begin
      pmag_r     <= pmag_nxt;
      prod_neg_r <= prod_r[31];
      acc_r      <= {18'd0, 50'(pmag_nxt * quo_r[17:0])};
    end
    if (cmd.mul_hi) acc_r <= acc_r + {50'(pmag_r * quo_r[35:18]), 18'd0};
    if (cmd.emit) begin
      out_score_r <= prod_r;
      out_sat_r   <= ovf_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_score     = out_score_r;
  assign out_saturated = out_sat_r;

endmodule

/* src/sinc_product_attention_score_top.sv */
// A zero argument skips straight to the multiply; a last word adds an emit step.
// Throughput: one word at a time; the 36 step radix-2 divider for sin(x)/|d| sets the rate.
// The running product multiply runs in the low and high partial-product states, then a round state.
// Output sits in a register, so a waiting score stalls only the next last word.
// Reset (rst_n low, synchronous): r_scale 1.0, product 1.0, saturation flag clear.
// Top level: sinc-product attention score with controller and datapath.
module sinc_product_attention_score_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [15:0]         cfg_r_scale,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [15:0]  in_query_elem,
  input  logic signed [15:0]  in_key_elem,
  input  logic                in_last_elem,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  out_score,
  output logic                out_saturated
);

  spas_pkg::cmd_t cmd;
  spas_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  spas_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  spas_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_r_scale   (cfg_r_scale),
    .in_query_elem (in_query_elem),
    .in_key_elem   (in_key_elem),
    .in_last_elem  (in_last_elem),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_score     (out_score),
    .out_saturated (out_saturated),
    .cmd           (cmd),
    .sts           (sts)
  );

endmodule

/* tb/tb_sinc_product_attention_score_top.sv */
// Testbench for the sinc-product attention score block, with scoreboard and random stimulus.
module tb_sinc_product_attention_score_top;

  localparam int  DRAIN_CYCLES = 80;
  localparam int  CYCLE_LIMIT  = 2000000;
  localparam longint unsigned RAD_TO_TURNS = 64'd683565276;
  localparam longint unsigned Q30_ONE      = 64'd1073741824;
  localparam longint unsigned Q30_HALF_PI  = 64'd1686629713;

  typedef struct {
    logic signed [31:0] score;
    logic               sat;
  } score_word_t;

  class score_board;
    logic [15:0]        bandwidth;
    logic signed [31:0] product;
    bit                 clamp_seen;
    score_word_t        pending_scores[$];
    longint             sine_lut[spas_pkg::SINE_DEPTH];
    int                 errors;
    int                 scores_seen;
    int                 sat_scores;

    function new();
      longint unsigned num;
      bandwidth  = spas_pkg::R_SCALE_RST;
      product    = 32'sd8388608;
      clamp_seen = 0;
      errors     = 0;
      scores_seen = 0;
      sat_scores = 0;
      for (int i = 0; i < spas_pkg::SINE_DEPTH; i++) begin
        num = (longint'(i) << 32) / spas_pkg::SINE_DEPTH;
        sine_lut[i] = taylor_sine(num[31:0]);
      end
    endfunction

    // Quadrant fold, then the odd series in Horner form with truncating steps.
    function longint taylor_sine(logic [31:0] ph);
      longint unsigned w, theta, t2, term, s;
      longint unsigned dens[6];
      dens = '{156, 110, 72, 42, 20, 6};
      w = {34'd0, ph[29:0]};
      if (ph[30]) w = Q30_ONE - w;
      theta = (w * Q30_HALF_PI) >> 30;
      t2 = (theta * theta) >> 30;
      term = Q30_ONE;
      for (int j = 0; j < 6; j++) term = Q30_ONE - (((t2 * term) >> 30) / dens[j]);
      s = (theta * term) >> 30;
      if (s > Q30_ONE) s = Q30_ONE;
      return ph[31] ? -longint'(s) : longint'(s);
    endfunction

    function longint interp_sine(longint unsigned ax);
      longint unsigned full, pos;
      logic [31:0] ph;
      int unsigned idx, nxt;
      longint a, b, f;
      full = ax * RAD_TO_TURNS;
      ph = full[55:24];
      pos = longint'(ph) * spas_pkg::SINE_DEPTH;
      idx = 32'(pos >> 32);
      f = (pos >> 16) & 64'hFFFF;
      nxt = (idx + 1 >= spas_pkg::SINE_DEPTH) ? 0 : idx + 1;
      a = sine_lut[idx];
      b = sine_lut[nxt];
      return (a * (65536 - f) + b * f) / 65536;
    endfunction

    function void accumulate(longint fac);
      longint prod;
      longint unsigned m, q;
      bit neg;
      prod = longint'(product) * fac;
      neg = prod < 0;
      m = neg ? longint'(-prod) : prod;
      q = (m + (64'd1 << 22)) >> 23;
      if (!neg && q > 64'h7FFFFFFF) begin
        clamp_seen = 1;
        product = 32'sh7FFFFFFF;
      end else if (neg && q > 64'h80000000) begin
        clamp_seen = 1;
        product = 32'sh80000000;
      end else begin
        product = 32'(neg ? -longint'(q) : longint'(q));
      end
    endfunction

    function void note_input(logic signed [15:0] q, logic signed [15:0] k, logic last);
      int d;
      longint unsigned ad, ax;
      longint fac;
      score_word_t w;
      d = int'(q) - int'(k);
      ad = (d < 0) ? -d : d;
      ax = ad * longint'(bandwidth);
      if (ax == 0) fac = longint'(bandwidth) << 11;
      else fac = (interp_sine(ax) * 32) / longint'(ad);
      accumulate(fac);
      if (last) begin
        w.score = product;
        w.sat = clamp_seen;
        pending_scores.push_back(w);
        product = 32'sd8388608;
        clamp_seen = 0;
      end
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch @%0t: %s", $time, msg);
    endtask

    task check_result(logic signed [31:0] score, logic sat);
      score_word_t w;
      if (pending_scores.size() == 0) begin
        report($sformatf("unexpected score %0d", score));
        return;
      end
      w = pending_scores.pop_front();
      scores_seen++;
      if (w.sat) sat_scores++;
      if (score !== w.score) report($sformatf("score %0d, want %0d", score, w.score));
      if (sat !== w.sat) report($sformatf("saturated %0b, want %0b", sat, w.sat));
    endtask
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_valid = 0, cfg_ready;
  logic [15:0] cfg_r_scale = '0;
  logic in_valid = 0, in_ready;
  logic signed [15:0] in_query_elem = '0, in_key_elem = '0;
  logic in_last_elem = 0;
  logic out_valid, out_ready = 0;
  logic signed [31:0] out_score;
  logic out_saturated;

  score_board sb;
  int  cycles = 0;
  bit  steady = 0;
  int  words_sent = 0;

  sinc_product_attention_score_top i_dut (
    .clk, .rst_n, .cfg_valid, .cfg_ready, .cfg_r_scale,
    .in_valid, .in_ready, .in_query_elem, .in_key_elem, .in_last_elem,
    .out_valid, .out_ready, .out_score, .out_saturated
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_input(in_query_elem, in_key_elem, in_last_elem);
    if (rst_n && out_valid && out_ready) sb.check_result(out_score, out_saturated);
  end

  function int pick_gap();
    int r;
    r = $urandom_range(99);
    if (steady || r < 65) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Stall the result side with the same short/long mix.
  int stall_left = 0;
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready = 0;
    end else begin
      stall_left = pick_gap();
      out_ready = (stall_left == 0);
    end
  end

  task send_word(logic signed [15:0] q, logic signed [15:0] k, logic last);
    int gap;
    @(negedge clk);
    in_valid = 1;
    in_query_elem = q;
    in_key_elem = k;
    in_last_elem = last;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    gap = pick_gap();
    // drop valid once the word is taken
    @(negedge clk);
    in_valid = 0;
    repeat (gap) @(negedge clk);
  endtask

  task drain();
    while (sb.pending_scores.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write the bandwidth register once the block has gone quiet.
  task write_bandwidth(logic [15:0] val);
    drain();
    @(negedge clk);
    in_valid = 0;
    cfg_valid = 1;
    cfg_r_scale = val;
    do @(posedge clk); while (!cfg_ready);
    sb.bandwidth = val;
    @(negedge clk);
    cfg_valid = 0;
  endtask

  task random_vectors(int n_words);
    int left, len, kind;
    logic signed [15:0] q, k;
    left = n_words;
    while (left > 0) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 6);
      for (int i = 0; i < len; i++) begin
        kind = $urandom_range(9);
        q = 16'($urandom);
        if (kind < 5) k = 16'($urandom);
        else if (kind < 8) k = q + $signed(16'($urandom_range(0, 64) - 32));
        else k = q;
        send_word(q, k, i == len - 1);
        left--;
      end
      if ($urandom_range(49) == 0) begin
        // hold off until every score is back
        while (sb.pending_scores.size() != 0) @(posedge clk);
      end
    end
  endtask

  initial begin
    logic [15:0] bw_list[8];
    sb = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed: reset bandwidth, extremes of the difference
    send_word(16'sd0, 16'sd0, 1);
    send_word(16'sd32767, -16'sd32768, 1);
    send_word(-16'sd32768, 16'sd32767, 1);
    send_word(16'sd100, -16'sd100, 0);
    send_word(16'sd5, 16'sd7, 0);
    send_word(16'sd9000, 16'sd1, 1);
    send_word(16'sd1, 16'sd0, 1);
    write_bandwidth(16'hFFFF);
    // equal elements at maximum bandwidth drive the product into saturation
    send_word(16'sd0, 16'sd0, 0);
    send_word(16'sd1234, 16'sd1234, 0);
    send_word(-16'sd7, -16'sd7, 1);
    send_word(16'sd32767, -16'sd32768, 1);
    send_word(16'sd3, 16'sd0, 0);
    send_word(16'sd2, 16'sd1, 1);
    send_word(16'sd0, 16'sd0, 1);
    write_bandwidth(16'h0000);
    send_word(16'sd123, -16'sd5, 1);
    send_word(16'sd0, 16'sd0, 0);
    send_word(-16'sd32768, 16'sd32767, 1);

    bw_list = '{16'd4096, 16'd1, 16'hFFFF, 16'd12000, 16'($urandom), 16'd0,
                16'($urandom), 16'd4096};
    foreach (bw_list[i]) begin
      write_bandwidth(bw_list[i]);
      steady = (i == 3);
      random_vectors(215);
    end
    steady = 0;

    @(negedge clk);
    in_valid = 0;
    drain();
    $display("sent %0d element words; checked %0d scores, %0d of them saturated",
             words_sent, sb.scores_seen, sb.sat_scores);
    $display("bandwidth settings covered 0, 1, 1.0, full scale and random values");
    if (sb.errors == 0 && sb.pending_scores.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
